// File: rtl/shell_word_splitter_unit_macros.svh
// Assertion macros shared by the word splitter checker.
`ifndef SHELL_WORD_SPLITTER_UNIT_MACROS_SVH
`define SHELL_WORD_SPLITTER_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define SWS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sws_pkg.sv
// Package for the shell word splitter: constants, state and result types.
`timescale 1ns / 1ps

package sws_pkg;

   localparam int MAX_WORDS = 64;
   localparam int WORD_TOP  = ((MAX_WORDS - 1) < 63) ? (MAX_WORDS - 1) : 63;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam logic [5:0] WORD_TOP_IDX = 6'(WORD_TOP);

   typedef enum logic [1:0] {
      QK_NONE   = 2'd0,
      QK_SINGLE = 2'd1,
      QK_DOUBLE = 2'd2
   } quote_kind_type;

   typedef struct packed {
      quote_kind_type quote_kind;
      logic           inside_quote;
      logic           escape_pending;
      logic           word_open;
      logic [5:0]     word_number;
   } split_state_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic [5:0] word_index;
      logic       word_end;
      logic       line_done;
   } split_result_type;

   localparam split_state_type STATE_RESET = '{
      quote_kind:     QK_NONE,
      inside_quote:   1'b0,
      escape_pending: 1'b0,
      word_open:      1'b0,
      word_number:    6'd0
   };

endpackage

// File: rtl/sws_step.sv
// Per-byte next-state and result logic of the word splitter.
`timescale 1ns / 1ps

module sws_step (
   input  sws_pkg::split_state_type  cur_state,
   input  logic [7:0]                in_byte,
   input  logic                      is_last,
   output sws_pkg::split_state_type  nxt_state,
   output sws_pkg::split_result_type result
);
   import sws_pkg::*;

   split_state_type st;
   quote_kind_type  kind;
   logic            valid;
   logic            wend;
   logic            is_quote;

   always_comb begin
      st       = cur_state;
      valid    = 1'b0;
      wend     = 1'b0;
      is_quote = (in_byte == CH_SQUOTE) || (in_byte == CH_DQUOTE);
      kind     = (in_byte == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;

      if (cur_state.word_number == 6'd0) begin
         // command name: spaces only
         if (in_byte == CH_SPACE) begin
            if (cur_state.word_open) begin
               wend = 1'b1;
            end
         end else begin
            valid        = 1'b1;
            st.word_open = 1'b1;
         end
      end else if (cur_state.escape_pending) begin
         st.escape_pending = 1'b0;
         valid             = 1'b1;
         st.word_open      = 1'b1;
      end else if (in_byte == CH_BSLASH && !cur_state.inside_quote) begin
         st.escape_pending = 1'b1;
         st.word_open      = 1'b1;
      end else if (is_quote) begin
         st.word_open = 1'b1;
         if (cur_state.quote_kind == QK_NONE) begin
            st.quote_kind   = kind;
            st.inside_quote = 1'b1;
         end else if (cur_state.quote_kind == kind) begin
            st.inside_quote = ~cur_state.inside_quote;
         end else begin
            valid = 1'b1;
         end
      end else if (in_byte == CH_SPACE && !cur_state.inside_quote) begin
         if (cur_state.word_open) begin
            wend = 1'b1;
         end
      end else begin
         valid        = 1'b1;
         st.word_open = 1'b1;
      end

      // word close: clear quote state and step the index
      if (wend) begin
         st.quote_kind     = QK_NONE;
         st.inside_quote   = 1'b0;
         st.escape_pending = 1'b0;
         st.word_open      = 1'b0;
         if (cur_state.word_number < WORD_TOP_IDX) begin
            st.word_number = cur_state.word_number + 6'd1;
         end
      end

      if (is_last) begin
         if (st.word_open) begin
            wend = 1'b1;
         end
         st = STATE_RESET;
      end

      nxt_state         = st;
      result.out_valid  = valid;
      result.out_byte   = valid ? in_byte : 8'd0;
      result.word_index = cur_state.word_number;
      result.word_end   = wend;
      result.line_done  = is_last;
   end

endmodule

// File: rtl/shell_word_splitter_unit.sv
// Top level of the shell word splitter.
//
// Splits a command line, fed one byte per req_ transfer (req_is_last on the
// final byte), into words. Every request transfer yields exactly one rsp_
// transfer: a word byte (rsp_out_valid), a word-end mark, both, or nothing.
// rsp_word_index numbers the word, 0 being the command name; it saturates
// at 63. rsp_line_done marks the response to the last byte.
// Latency: the response is presented the cycle after the request transfer.
// Throughput: one byte per cycle unless stalled, set by the single result
// register; splitter state is updated in the same cycle the byte is taken.
// A request is taken while the result register is empty or being drained,
// so req_stall follows rsp_stall only when a result is held.
// Reset (synchronous) empties the result register and returns the splitter
// to the start of a line. While rsp_stall is high the held result stays put.
`timescale 1ns / 1ps

module shell_word_splitter_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic [5:0] rsp_word_index,
   output logic       rsp_word_end,
   output logic       rsp_line_done
);
   import sws_pkg::*;

   split_state_type  state_ff;
   split_state_type  state_in;
   split_result_type result_ff;
   split_result_type result_in;
   logic             rsp_valid_ff;
   logic             req_take;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   sws_step u_step (
      .cur_state (state_ff),
      .in_byte   (req_in_byte),
      .is_last   (req_is_last),
      .nxt_state (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_valid  = result_ff.out_valid;
   assign rsp_out_byte   = result_ff.out_byte;
   assign rsp_word_index = result_ff.word_index;
   assign rsp_word_end   = result_ff.word_end;
   assign rsp_line_done  = result_ff.line_done;

endmodule

// File: rtl/sws_checker.sv
// Port-level checker for the shell word splitter, bound to the top level.
`timescale 1ns / 1ps
`include "shell_word_splitter_unit_macros.svh"

module sws_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_out_valid,
   input logic [7:0] rsp_out_byte,
   input logic [5:0] rsp_word_index,
   input logic       rsp_word_end,
   input logic       rsp_line_done
);
   import sws_pkg::*;

   // empty items carry a zero byte
   `SWS_ASSERT_IMPLY(a_empty_byte_zero, clock, reset, rsp_valid && !rsp_out_valid, rsp_out_byte == 8'd0, "byte set on empty item")

   // a space closes a word and carries no byte, except on the last byte
   `SWS_ASSERT_IMPLY(a_close_no_byte, clock, reset, rsp_valid && rsp_word_end && !rsp_line_done, !rsp_out_valid, "byte on mid-line word end")

   // the command name never holds a space
   `SWS_ASSERT_IMPLY(a_name_no_space, clock, reset, rsp_valid && rsp_out_valid && rsp_word_index == 6'd0, rsp_out_byte != CH_SPACE, "space in command name")

   // a stalled response holds
   `SWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_word_index), "stalled response changed")

   // input is held off only behind a stalled, held result
   `SWS_ASSERT_IMPLY(a_req_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without a held result")

endmodule

bind shell_word_splitter_unit sws_checker u_sws_checker (.*);
